[rtl/core/lebuf_pkg.sv]
// lebuf_pkg: shared constants, command type and result sequencing functions
// for the line edit input buffer. No dependencies.
`default_nettype none
package lebuf_pkg;

  localparam int LINE_DEPTH  = 512;
  localparam int IDX_W       = $clog2(LINE_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // input modes
  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_DISCARD = 2'd2;

  // destinations
  localparam logic DEST_ECHO   = 1'b0;
  localparam logic DEST_READER = 1'b1;

  // character codes
  localparam logic [7:0] KEY_DELETE    = 8'h7f;
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_CR        = 8'h0d;
  localparam logic [7:0] KEY_NL        = 8'h0a;
  localparam logic [7:0] CHAR_O        = 8'h6f;
  localparam logic [7:0] CHAR_K        = 8'h6b;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // command kinds handed from front to back
  localparam logic [2:0] CMD_ECHO      = 3'd0;  // echo one key
  localparam logic [2:0] CMD_DELETE    = 3'd1;  // BS, space, BS
  localparam logic [2:0] CMD_READ      = 3'd2;  // one byte to reader
  localparam logic [2:0] CMD_NL_READ   = 3'd3;  // NL echo, then byte to reader
  localparam logic [2:0] CMD_PROMPT    = 3'd4;  // o, k, space
  localparam logic [2:0] CMD_NL_PROMPT = 3'd5;  // NL, o, k, space

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } cmd_t;

  // index of the final result of a command
  function automatic logic [1:0] seq_last(input logic [2:0] kind);
    logic [1:0] n;
    case (kind)
      CMD_ECHO:      n = 2'd0;
      CMD_DELETE:    n = 2'd2;
      CMD_READ:      n = 2'd0;
      CMD_NL_READ:   n = 2'd1;
      CMD_PROMPT:    n = 2'd2;
      CMD_NL_PROMPT: n = 2'd3;
      default:       n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [1:0] step,
                                          input logic [7:0] data);
    logic [7:0] b;
    b = data;
    case (kind)
      CMD_ECHO:    b = data;
      CMD_DELETE:  b = (step == 2'd1) ? CHAR_SPACE : KEY_BACKSPACE;
      CMD_READ:    b = data;
      CMD_NL_READ: b = (step == 2'd0) ? KEY_NL : data;
      CMD_PROMPT: begin
        case (step)
          2'd0:    b = CHAR_O;
          2'd1:    b = CHAR_K;
          default: b = CHAR_SPACE;
        endcase
      end
      CMD_NL_PROMPT: begin
        case (step)
          2'd0:    b = KEY_NL;
          2'd1:    b = CHAR_O;
          2'd2:    b = CHAR_K;
          default: b = CHAR_SPACE;
        endcase
      end
      default: b = data;
    endcase
    return b;
  endfunction

  function automatic logic seq_dest(input logic [2:0] kind, input logic [1:0] step);
    logic d;
    d = DEST_ECHO;
    if (kind == CMD_READ) d = DEST_READER;
    if (kind == CMD_NL_READ && step == 2'd1) d = DEST_READER;
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lebuf_req_if.sv]
// lebuf_req_if: input channel of the line edit input buffer.
// Payload is mode and key byte; no dependencies.
`default_nettype none
interface lebuf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] key_byte;

  modport source (output valid, output mode, output key_byte, input ready);
  modport sink   (input valid, input mode, input key_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/lebuf_rsp_if.sv]
// lebuf_rsp_if: result channel of the line edit input buffer.
// Payload is destination, byte and last flag; no dependencies.
`default_nettype none
interface lebuf_rsp_if;
  logic       valid;
  logic       ready;
  logic       destination;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output destination, output out_byte, output last,
                  input ready);
  modport sink   (input valid, input destination, input out_byte, input last,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/line_edit_input_buffer.sv]
// line_edit_input_buffer: terminal line editor, top level.
// Path: the first result of an item passes the front register, the queue and
// the output register; a full queue or a stalled output can hold it on the way.
// Results: one result per cycle out of the back end while the output is not
// stalled; an item gives 0 to 4 results there, while the front takes one item
// per cycle as long as the 4-entry command queue has room.
// Reset (synchronous, rst high): indices zero, not collecting, queue and output empty.
`default_nettype none
module line_edit_input_buffer (
  input  wire logic   clk,
  input  wire logic   rst,
  lebuf_req_if.sink   req,
  lebuf_rsp_if.source rsp
);

  // Front: owns write/read indices, the collecting flag and the 512-byte
  // line store. Each accepted item is classified at once and the indices
  // updated, so the next item sees the new state in the following cycle.
  // Store reads for reader answers are issued at acceptance; a CR that
  // writes the same entry it reads is bypassed to NL.
  logic            push_valid;
  logic            push_ready;
  lebuf_pkg::cmd_t push_cmd;

  // Queue: decouples the front from the back so keys keep flowing while
  // multi-byte echoes (delete, prompt) drain.
  logic            pop_valid;
  logic            pop;
  lebuf_pkg::cmd_t pop_cmd;

  lebuf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lebuf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  // Back: steps through the command's byte sequence into the output
  // register; last is set on the command's final byte.
  lebuf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[rtl/core/lebuf_front.sv]
// lebuf_front: accepts items, keeps indices and the line store, classifies
// each item into a command. Depends on lebuf_pkg and lebuf_req_if.
`default_nettype none
module lebuf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  lebuf_req_if.sink            req,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output lebuf_pkg::cmd_t      push_cmd
);

  logic [7:0] mem [lebuf_pkg::LINE_DEPTH];
  logic [7:0] mem_q;

  logic [lebuf_pkg::IDX_W-1:0] wr, rd, wr_next, rd_next, wr_inc, rd_inc;
  logic collecting, collecting_next;

  logic       accept;
  logic       has_result;
  logic [2:0] kind;
  logic       mem_we;
  logic [7:0] mem_wdata;
  logic       use_mem;
  logic       bypass;

  logic       s2_valid;
  logic [2:0] s2_kind;
  logic [7:0] s2_key;
  logic       s2_use_mem;
  logic       s2_bypass;

  function automatic logic [lebuf_pkg::IDX_W-1:0] idx_inc(
      input logic [lebuf_pkg::IDX_W-1:0] i);
    logic [lebuf_pkg::IDX_W-1:0] r;
    if (i == lebuf_pkg::IDX_W'(lebuf_pkg::LINE_DEPTH - 1)) r = '0;
    else r = i + 1'b1;
    return r;
  endfunction

  assign req.ready = !s2_valid || push_ready;
  assign accept    = req.valid && req.ready;
  assign wr_inc    = idx_inc(wr);
  assign rd_inc    = idx_inc(rd);
  assign mem_wdata = (req.key_byte == lebuf_pkg::KEY_CR) ? lebuf_pkg::KEY_NL : req.key_byte;

  always_comb begin
    wr_next         = wr;
    rd_next         = rd;
    collecting_next = collecting;
    has_result      = 1'b0;
    kind            = lebuf_pkg::CMD_ECHO;
    mem_we          = 1'b0;
    use_mem         = 1'b0;
    bypass          = 1'b0;
    case (req.mode)
      lebuf_pkg::MODE_KEY: begin
        if (collecting) begin
          if (req.key_byte == lebuf_pkg::KEY_CR) begin
            mem_we          = 1'b1;
            has_result      = 1'b1;
            collecting_next = 1'b0;
            if (rd != wr_inc) begin
              // line done: answer the pending read, store may alias the NL
              kind    = lebuf_pkg::CMD_NL_READ;
              use_mem = 1'b1;
              bypass  = (rd == wr);
              wr_next = wr_inc;
              rd_next = rd_inc;
            end else begin
              // line wrapped onto the read index: prompt again
              kind            = lebuf_pkg::CMD_NL_PROMPT;
              wr_next         = '0;
              rd_next         = '0;
              collecting_next = 1'b1;
            end
          end else if (req.key_byte == lebuf_pkg::KEY_DELETE) begin
            if (wr != '0) begin
              has_result = 1'b1;
              kind       = lebuf_pkg::CMD_DELETE;
              wr_next    = wr - 1'b1;
            end
          end else begin
            has_result = 1'b1;
            kind       = lebuf_pkg::CMD_ECHO;
            mem_we     = 1'b1;
            wr_next    = wr_inc;
          end
        end
      end
      lebuf_pkg::MODE_READ: begin
        if (!collecting) begin
          has_result = 1'b1;
          if (rd != wr) begin
            kind    = lebuf_pkg::CMD_READ;
            use_mem = 1'b1;
            rd_next = rd_inc;
          end else begin
            kind            = lebuf_pkg::CMD_PROMPT;
            wr_next         = '0;
            rd_next         = '0;
            collecting_next = 1'b1;
          end
        end
      end
      lebuf_pkg::MODE_DISCARD: begin
        rd_next = wr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr         <= '0;
      rd         <= '0;
      collecting <= 1'b0;
    end else if (accept) begin
      wr         <= wr_next;
      rd         <= rd_next;
      collecting <= collecting_next;
    end
  end

  // line store: write at write index, registered read at read index
  always_ff @(posedge clk) begin
    if (accept && mem_we) mem[wr] <= mem_wdata;
    if (accept && has_result) mem_q <= mem[rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept && has_result) begin
      s2_valid <= 1'b1;
    end else if (push_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      s2_kind    <= kind;
      s2_key     <= req.key_byte;
      s2_use_mem <= use_mem;
      s2_bypass  <= bypass;
    end
  end

  assign push_valid    = s2_valid;
  assign push_cmd.kind = s2_kind;
  assign push_cmd.data = s2_use_mem ? (s2_bypass ? lebuf_pkg::KEY_NL : mem_q) : s2_key;

endmodule
`default_nettype wire

[rtl/core/lebuf_queue.sv]
// lebuf_queue: short command queue between front and back.
// Depends on lebuf_pkg.
`default_nettype none
module lebuf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire lebuf_pkg::cmd_t  push_cmd,
  output logic                  pop_valid,
  input  wire logic             pop,
  output lebuf_pkg::cmd_t       pop_cmd
);

  lebuf_pkg::cmd_t entries [lebuf_pkg::QUEUE_DEPTH];
  logic [lebuf_pkg::QPTR_W-1:0] wptr, rptr;
  logic [lebuf_pkg::QPTR_W:0]   count;
  logic do_push, do_pop;

  assign push_ready = (count != (lebuf_pkg::QPTR_W+1)'(lebuf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_cmd;
  end

endmodule
`default_nettype wire

[rtl/core/lebuf_back.sv]
// lebuf_back: expands queued commands into result items, one per cycle while
// not stalled, through an output register. Depends on lebuf_pkg, lebuf_rsp_if.
`default_nettype none
module lebuf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop,
  input  wire lebuf_pkg::cmd_t  pop_cmd,
  lebuf_rsp_if.source           rsp
);

  logic [1:0] step;
  logic       load;
  logic       at_last;
  logic       out_valid;
  logic       out_dest;
  logic [7:0] out_data;
  logic       out_last;

  assign load    = pop_valid && (!out_valid || rsp.ready);
  assign at_last = (step == lebuf_pkg::seq_last(pop_cmd.kind));
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= at_last ? 2'd0 : step + 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_dest <= lebuf_pkg::seq_dest(pop_cmd.kind, step);
      out_data <= lebuf_pkg::seq_byte(pop_cmd.kind, step, pop_cmd.data);
      out_last <= at_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.destination = out_dest;
  assign rsp.out_byte    = out_data;
  assign rsp.last        = out_last;

endmodule
`default_nettype wire

[rtl/core/lebuf_checker.sv]
// lebuf_checker: port-level assertions for line_edit_input_buffer, bound
// to the top level. Depends on lebuf_pkg and line_edit_input_buffer.
`default_nettype none
module lebuf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_destination,
  input wire logic [7:0] rsp_out_byte,
  input wire logic       rsp_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_destination) && $stable(rsp_last))
    else $error("result changed while stalled");

  // a reader answer always closes its item
  a_reader_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_destination |-> rsp_last)
    else $error("reader byte not last");

  // prompt 'o' is followed directly by 'k'
  a_prompt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_destination && rsp_out_byte == lebuf_pkg::CHAR_O
      && !rsp_last |=> rsp_valid && rsp_out_byte == lebuf_pkg::CHAR_K)
    else $error("broken prompt");

  // erase echo: backspace then space
  a_erase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_destination && rsp_out_byte == lebuf_pkg::KEY_BACKSPACE
      && !rsp_last |=> rsp_valid && rsp_out_byte == lebuf_pkg::CHAR_SPACE)
    else $error("broken erase echo");

endmodule

bind line_edit_input_buffer lebuf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_destination (rsp.destination),
  .rsp_out_byte    (rsp.out_byte),
  .rsp_last        (rsp.last)
);
`default_nettype wire

[test/line_edit_checker.sv]
// line_edit_checker: watches both channels of the line edit input buffer, predicts
// the echo and reader bytes of every accepted item and compares them in order.
// Depends on lebuf_pkg, lebuf_req_if and lebuf_rsp_if.
module line_edit_checker
  import lebuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lebuf_req_if        req,
  lebuf_rsp_if        rsp,
  output int unsigned pending,
  output int unsigned errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // LINE_DEPTH is a power of two, so the indices wrap by overflow
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } line_out_t;

  logic [7:0] line_mem [LINE_DEPTH];
  idx_t       wr_idx;
  idx_t       rd_idx;
  logic       taking_line;
  line_out_t  expected_bytes [$];
  line_out_t  burst [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic emit(input logic dest, input logic [7:0] data);
    burst.push_back('{dest: dest, data: data, last: 1'b0});
  endtask

  task automatic open_line();
    rd_idx = '0;
    wr_idx = '0;
    emit(DEST_ECHO, CHAR_O);
    emit(DEST_ECHO, CHAR_K);
    emit(DEST_ECHO, CHAR_SPACE);
    taking_line = 1'b1;
  endtask

  task automatic hand_to_reader();
    emit(DEST_READER, line_mem[rd_idx]);
    rd_idx++;
  endtask

  task automatic edit_line(input logic [1:0] mode, input logic [7:0] key);
    burst.delete();
    case (mode)
      MODE_KEY: begin
        if (taking_line) begin
          if (key == KEY_CR) begin
            line_mem[wr_idx] = KEY_NL;
            wr_idx++;
            emit(DEST_ECHO, KEY_NL);
            taking_line = 1'b0;
            if (rd_idx != wr_idx) hand_to_reader();
            else open_line();
          end else if (key == KEY_DELETE) begin
            if (wr_idx != '0) begin
              emit(DEST_ECHO, KEY_BACKSPACE);
              emit(DEST_ECHO, CHAR_SPACE);
              emit(DEST_ECHO, KEY_BACKSPACE);
              wr_idx--;
            end
          end else begin
            emit(DEST_ECHO, key);
            line_mem[wr_idx] = key;
            wr_idx++;
          end
        end
      end
      MODE_READ: begin
        if (!taking_line) begin
          if (rd_idx != wr_idx) hand_to_reader();
          else open_line();
        end
      end
      MODE_DISCARD: rd_idx = wr_idx;
      default: ;
    endcase
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    line_out_t want;
    if (rst) begin
      wr_idx = '0;
      rd_idx = '0;
      taking_line = 1'b0;
      expected_bytes.delete();
    end else begin
      if (req.valid && req.ready) edit_line(req.mode, req.key_byte);
      if (rsp.valid && rsp.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("result dest %0d byte %02h with nothing expected",
                                    rsp.destination, rsp.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (rsp.destination !== want.dest)
            report_mismatch($sformatf("destination %0d, expected %0d",
                                      rsp.destination, want.dest));
          if (rsp.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      rsp.out_byte, want.data));
          if (rsp.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d (byte %02h)",
                                      rsp.last, want.last, want.data));
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

[test/line_edit_input_buffer_test.sv]
// line_edit_input_buffer_test: drives keyboard, read, discard and unused-mode items into the
// line edit input buffer under varying idle and stall, and gives the verdict.
// Depends on lebuf_pkg, both channel interfaces, line_edit_input_buffer and line_edit_checker.
module line_edit_input_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lebuf_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;  // not decoded by the block
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          PHASE_ITEMS = 85;
  localparam int          DEL_PCT     = 15;

  typedef logic [IDX_W-1:0] idx_t;

  logic        clk;
  logic        rst;
  int unsigned cycles;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int          sent;

  // Index bookkeeping on the stimulus side. Its only job is to keep the block
  // from ever answering a read out of a store entry nobody has written yet.
  bit   st_taking;
  idx_t st_wr;
  idx_t st_rd;
  bit   st_written [LINE_DEPTH];

  lebuf_req_if req ();
  lebuf_rsp_if rsp ();

  line_edit_input_buffer u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  line_edit_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .pending (pending),
    .errors  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Reader side: ready drops at random, in stall_pct percent of the cycles on average.
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hard stop in case the block hangs or never drains.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("line_edit_input_buffer_test: errors");
      $finish;
    end
  end

  // One item through the request channel. valid stays high from one item to
  // the next unless an idle cycle is drawn, so it is never lowered and raised
  // in the same step.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] key);
    logic [1:0] m;
    bit         blank;
    idx_t       wr_next;
    do begin
      // Would this item read an entry never written? That happens when the
      // read index got ahead of the write index (discard, then deletes).
      wr_next = st_wr + 1'b1;
      blank = 1'b0;
      if (mode == MODE_READ && !st_taking)
        blank = (st_rd != st_wr) && !st_written[st_rd];
      if (mode == MODE_KEY && st_taking && key == KEY_CR)
        blank = (st_rd != st_wr) && (st_rd != wr_next) && !st_written[st_rd];
      // a discard pulls the read index back onto the write index first
      m = blank ? MODE_DISCARD : mode;

      while ($urandom_range(0, 99) < idle_pct) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
      req.valid    <= 1'b1;
      req.mode     <= m;
      req.key_byte <= key;
      do @(posedge clk); while (!req.ready);
      sent++;

      case (m)
        MODE_KEY: begin
          if (st_taking) begin
            if (key == KEY_CR) begin
              st_written[st_wr] = 1'b1;
              st_wr++;
              st_taking = 1'b0;
              if (st_rd != st_wr) begin
                st_rd++;
              end else begin
                st_rd = '0;
                st_wr = '0;
                st_taking = 1'b1;
              end
            end else if (key == KEY_DELETE) begin
              if (st_wr != '0) st_wr--;
            end else begin
              st_written[st_wr] = 1'b1;
              st_wr++;
            end
          end
        end
        MODE_READ: begin
          if (!st_taking) begin
            if (st_rd != st_wr) begin
              st_rd++;
            end else begin
              st_rd = '0;
              st_wr = '0;
              st_taking = 1'b1;
            end
          end
        end
        MODE_DISCARD: st_rd = st_wr;
        default: ;
      endcase
    end while (blank);
  endtask

  // A well formed session: read request (prompt), typed keys with some
  // deletes and discards, carriage return, then a few reads.
  task automatic random_line(input int len, input int del_pct);
    int         roll;
    int         reads;
    logic [7:0] k;
    send_item(MODE_READ, 8'($urandom_range(0, 255)));
    repeat (len) begin
      roll = $urandom_range(0, 99);
      if (roll < del_pct) begin
        send_item(MODE_KEY, KEY_DELETE);
      end else if (roll < del_pct + 4) begin
        send_item(MODE_DISCARD, 8'($urandom_range(0, 255)));
      end else begin
        do k = 8'($urandom_range(0, 255)); while (k == KEY_CR);
        send_item(MODE_KEY, k);
      end
    end
    send_item(MODE_KEY, KEY_CR);
    reads = $urandom_range(0, (len > 12 ? 12 : len) + 3);
    repeat (reads) send_item(MODE_READ, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    // every block input known from time zero
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.mode     = MODE_KEY;
    req.key_byte = 8'h00;
    rsp.ready    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    st_taking    = 1'b0;
    st_wr        = '0;
    st_rd        = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    send_item(MODE_KEY, 8'h61);        // key while not collecting: dropped
    send_item(MODE_READ, 8'h00);       // empty store: prompt, start collecting
    send_item(MODE_READ, 8'hff);       // read already pending: nothing
    send_item(MODE_KEY, KEY_DELETE);   // delete on empty line: nothing
    send_item(MODE_KEY, 8'h00);
    send_item(MODE_KEY, 8'hff);
    send_item(MODE_KEY, 8'h78);
    send_item(MODE_KEY, KEY_DELETE);   // BS, space, BS
    send_item(MODE_UNUSED, 8'hff);     // ignored
    send_item(MODE_KEY, KEY_CR);       // newline echo, then first byte to reader
    send_item(MODE_READ, 8'h00);
    send_item(MODE_READ, 8'h00);       // the stored newline
    send_item(MODE_READ, 8'h00);       // drained: prompt again
    // carriage return landing on the read index: newline plus a fresh prompt
    send_item(MODE_KEY, 8'h71);
    send_item(MODE_DISCARD, 8'h00);
    send_item(MODE_KEY, KEY_DELETE);
    send_item(MODE_KEY, KEY_CR);
    send_item(MODE_KEY, 8'h55);
    send_item(MODE_KEY, 8'haa);
    send_item(MODE_KEY, KEY_CR);
    send_item(MODE_DISCARD, 8'hff);    // drop the rest of the line
    send_item(MODE_READ, 8'h00);       // empty again: prompt

    // --- random part, four idling phases ---
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 20;
          stall_pct = 20;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly sessions, some raw noise items of any mode
        if ($urandom_range(0, 9) < 7)
          random_line($urandom_range(0, 12), DEL_PCT);
        else
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    req.valid <= 1'b0;

    // drain, then keep waiting to catch stray results
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("line_edit_input_buffer_test: clean");
    end else begin
      $display("line_edit_input_buffer_test: errors");
    end
    $finish;
  end

endmodule
